// ===== design/epsp_pkg.sv =====
package epsp_pkg;

	// Escape / show character and the run length past which data mode is left
	localparam logic [7:0] ESCAPE_BYTE    = 8'hFF;
	localparam logic [3:0] RUN_TO_COMMAND = 4'd8;
	localparam logic [3:0] RUN_MAX        = 4'd15;

	// Triple slot holding the last color byte
	localparam logic [1:0] LAST_SLOT = 2'd2;

	typedef enum logic {
		EV_PIXEL = 1'b0,
		EV_SHOW  = 1'b1
	} event_kind_t;

	typedef struct packed {
		event_kind_t kind;
		logic [2:0]  column;
		logic [2:0]  row;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
	} result_t;

endpackage

// ===== design/escaped_pixel_stream_parser_core.sv =====
// Escaped pixel stream parser. Takes one received byte per clock on the slave
// stream (s_tdata[7:0]) while s_tready is high and emits pixel writes and
// show events on the master stream. A result, when a byte causes one, is
// decided combinationally and registered in the result register, or in the
// skid register while the master side stalls; the sustained rate is one byte
// per cycle while the master side accepts. The two-beat output buffer lets the
// input keep flowing for one beat while the master side stalls; s_tready drops
// only when both registers are full. Pixel column and row come from running
// counters (COLUMNS wide rows, up to PIXELS pixels); both are reported in 3 bits.
module escaped_pixel_stream_parser_core import epsp_pkg::*; #(
	parameter int COLUMNS = 8,
	parameter int PIXELS  = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // [2:0] column, [5:3] row, [13:6] red,
	                              // [21:14] green, [29:22] blue, [31:30] zero
	output logic        m_tuser   // [0] event_kind
);

	logic    beat;
	logic    res_valid;
	result_t res;

	logic    out_valid_q;
	result_t out_q;
	logic    skid_valid_q;
	result_t skid_q;

	assign s_tready = !skid_valid_q;
	assign beat     = s_tvalid && s_tready;

	epsp_parse #(
		.COLUMNS (COLUMNS),
		.PIXELS  (PIXELS)
	) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.beat      (beat),
		.rx_byte   (s_tdata),
		.res_valid (res_valid),
		.res       (res)
	);

	// Output register with one skid stage behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (!out_valid_q || m_tready) begin
				if (skid_valid_q) begin
					out_valid_q  <= 1'b1;
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= res_valid;
				end
			end else if (res_valid) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || m_tready) begin
			out_q <= skid_valid_q ? skid_q : res;
		end
		if (res_valid && out_valid_q && !m_tready) begin
			skid_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.kind;
	assign m_tdata  = {2'b00, out_q.blue, out_q.green, out_q.red, out_q.row, out_q.column};

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q) else $error("skid full with output empty");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && m_tready |=> out_valid_q && !skid_valid_q)
		else $error("skid beat not moved to output");

	a_stall_fills_skid: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && out_valid_q && !m_tready |=> skid_valid_q)
		else $error("result lost while output stalled");

endmodule

// ===== design/epsp_parse.sv =====
module epsp_parse import epsp_pkg::*; #(
	parameter int COLUMNS = 8,
	parameter int PIXELS  = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       beat,      // a byte is taken this cycle
	input  logic [7:0] rx_byte,
	output logic       res_valid,
	output result_t    res
);

	localparam int CW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
	localparam int PW = $clog2(PIXELS + 1);
	localparam logic [CW-1:0] COL_LAST  = CW'(COLUMNS - 1);
	localparam logic [PW-1:0] PIX_COUNT = PW'(PIXELS);

	logic          cmd_q;
	logic [3:0]    run_q;
	logic [1:0]    pos_q;
	logic [7:0]    held_q [2];
	logic [PW-1:0] pix_q;
	logic [CW-1:0] col_q;
	logic [PW-1:0] row_q;

	logic       is_esc;
	logic [3:0] run_next;
	logic       pix_room;

	assign is_esc   = (rx_byte == ESCAPE_BYTE);
	assign run_next = (run_q == RUN_MAX) ? RUN_MAX : run_q + 4'd1;
	assign pix_room = (pix_q < PIX_COUNT);

	// Decide the result for this byte from the current state
	always_comb begin
		res_valid  = 1'b0;
		res.kind   = EV_PIXEL;
		res.column = 3'(col_q);
		res.row    = 3'(row_q);
		res.red    = held_q[0];
		res.green  = held_q[1];
		res.blue   = rx_byte;
		if (beat && !cmd_q) begin
			if (!is_esc) begin
				res_valid = (pos_q == LAST_SLOT) && pix_room;
			end else begin
				res_valid  = (run_next == 4'd1);
				res.kind   = EV_SHOW;
				res.column = '0;
				res.row    = '0;
				res.red    = '0;
				res.green  = '0;
				res.blue   = '0;
			end
		end
	end

	// Hold the red and green bytes of the triple being gathered
	always_ff @(posedge clk) begin
		if (beat && !cmd_q && !is_esc && pos_q != LAST_SLOT) begin
			held_q[pos_q[0]] <= rx_byte;
		end
	end

	// Advance mode, run, triple slot and pixel counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q <= 1'b0;
			run_q <= '0;
			pos_q <= '0;
			pix_q <= '0;
			col_q <= '0;
			row_q <= '0;
		end else if (beat) begin
			if (cmd_q) begin
				if (!is_esc) begin
					cmd_q <= 1'b0;
					run_q <= '0;
					pos_q <= '0;
					pix_q <= '0;
					col_q <= '0;
					row_q <= '0;
				end
			end else if (!is_esc) begin
				run_q <= '0;
				if (pos_q != LAST_SLOT) begin
					pos_q <= pos_q + 2'd1;
				end else begin
					pos_q <= '0;
					if (pix_room) begin
						pix_q <= pix_q + PW'(1);
						if (col_q == COL_LAST) begin
							col_q <= '0;
							row_q <= row_q + PW'(1);
						end else begin
							col_q <= col_q + CW'(1);
						end
					end
				end
			end else begin
				pos_q <= '0;
				pix_q <= '0;
				col_q <= '0;
				row_q <= '0;
				run_q <= run_next;
				if (run_next > RUN_TO_COMMAND) begin
					cmd_q <= 1'b1;
				end
			end
		end
	end

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q != 2'd3) else $error("triple slot out of range");

	a_pix_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pix_q <= PIX_COUNT && col_q <= COL_LAST) else $error("pixel counter past end");

	a_cmd_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_q |-> !res_valid) else $error("result in command mode");

	a_ninth_escape: assert property (@(posedge clk) disable iff (!arst_n)
		beat && !cmd_q && is_esc && run_q == RUN_TO_COMMAND |=> cmd_q)
		else $error("ninth escape did not enter command mode");

endmodule
